// ----- rtl/ecw_pkg.sv -----
// Shared constants and types for the Euler circuit walker.
// Holds sizes, request codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ecw_pkg;

    // Sizes
    localparam int MAX_VERTICES = 8;
    localparam int STACK_DEPTH  = 29;
    localparam int RESULT_LIMIT = 29;
    localparam int VTX_W        = 3;
    localparam int ROWBITS_W    = 8;
    localparam int ROW_W        = MAX_VERTICES;
    localparam int VCNT_W       = 4;
    localparam int VCNT_RESET   = 8;
    localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
    localparam int SADDR_W      = $clog2(STACK_DEPTH);
    localparam int TAKEN_W      = $clog2(RESULT_LIMIT);

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_WALK = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_row;
        logic walk_init;
        logic pop;
        logic load_u;
        logic take_edge;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic stack_empty;
        logic edge_ok;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/ecw_in_if.sv -----
// Request channel of the Euler circuit walker: valid/ready plus request payload.
// Depends on ecw_pkg.
`default_nettype none

interface ecw_in_if import ecw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [VTX_W-1:0]     row_index;
    logic [ROWBITS_W-1:0] row_bits;
    logic [VTX_W-1:0]     start_vertex;

    modport source (output valid, req_type, row_index, row_bits, start_vertex, input ready);
    modport sink   (input valid, req_type, row_index, row_bits, start_vertex, output ready);
endinterface

`default_nettype wire

// ----- rtl/ecw_out_if.sv -----
// Result channel of the Euler circuit walker: valid/ready plus emitted vertex.
// Depends on ecw_pkg.
`default_nettype none

interface ecw_out_if import ecw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] vertex_out;
    logic             last_vertex;

    modport source (output valid, vertex_out, last_vertex, input ready);
    modport sink   (input valid, vertex_out, last_vertex, output ready);
endinterface

`default_nettype wire

// ----- rtl/ecw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ecw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/ecw_dp.sv -----
// Datapath of the Euler circuit walker: adjacency rows, vertex stack, edge picker
// and result register. Depends on ecw_pkg and ecw_ram.
`default_nettype none

module ecw_dp import ecw_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [VCNT_W-1:0]    i_cfg_wdata,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic [VTX_W-1:0]     i_row_index,
    input  wire logic [ROWBITS_W-1:0] i_row_bits,
    input  wire logic [VTX_W-1:0]     i_start_vertex,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic      [VTX_W-1:0]     o_vertex_out,
    output logic                      o_last_vertex
);

    logic [ROW_W-1:0]   r_rows [MAX_VERTICES];
    logic [VCNT_W-1:0]  r_vcnt;
    logic [CNT_W-1:0]   r_count;
    logic [TAKEN_W-1:0] r_taken;
    logic [VTX_W-1:0]   r_u;
    logic               r_out_valid;
    logic [VTX_W-1:0]   r_out_vertex;
    logic               r_out_last;

    logic [ROW_W-1:0]   col_mask;
    logic [ROW_W-1:0]   row_sel;
    logic [ROW_W-1:0]   cand;
    logic [VTX_W-1:0]   v_sel;
    logic               has_edge;
    logic [ROW_W-1:0]   clr [MAX_VERTICES];
    logic [CNT_W-1:0]   cnt_dec;
    logic               stk_we;
    logic [SADDR_W-1:0] stk_waddr;
    logic [VTX_W-1:0]   stk_wdata;
    logic [VTX_W-1:0]   stk_rdata;

    // Columns below the vertex count take part in the scan
    always_comb begin
        for (int c = 0; c < MAX_VERTICES; c++) begin
            col_mask[c] = (VCNT_W'(c) < r_vcnt);
        end
    end

    // Row of the current vertex; lowest set column wins
    always_comb begin
        row_sel = '0;
        for (int r = 0; r < MAX_VERTICES; r++) begin
            if (VTX_W'(r) == r_u) begin
                row_sel = r_rows[r];
            end
        end
        cand     = row_sel & col_mask;
        has_edge = |cand;
        v_sel    = '0;
        for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
            if (cand[c]) begin
                v_sel = VTX_W'(c);
            end
        end
    end

    // Bits cleared when edge (u,v) is taken: (u,v) and (v,u)
    always_comb begin
        for (int r = 0; r < MAX_VERTICES; r++) begin
            for (int c = 0; c < MAX_VERTICES; c++) begin
                clr[r][c] = ((VTX_W'(r) == r_u) && (VTX_W'(c) == v_sel)) ||
                            ((VTX_W'(r) == v_sel) && (VTX_W'(c) == r_u));
            end
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.stack_empty = (r_count == '0);
        o_stat.edge_ok     = has_edge && (r_count < CNT_W'(STACK_DEPTH)) &&
                             (r_taken < TAKEN_W'(RESULT_LIMIT - 1));
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // Stack access: start vertex at the bottom on init, u pushed on each edge
    assign cnt_dec   = r_count - CNT_W'(1);
    assign stk_we    = i_cmd.walk_init || i_cmd.take_edge;
    assign stk_waddr = i_cmd.walk_init ? '0 : r_count[SADDR_W-1:0];
    assign stk_wdata = i_cmd.walk_init ? i_start_vertex : r_u;

    ecw_ram #(
        .WIDTH (VTX_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (cnt_dec[SADDR_W-1:0]),
        .o_rdata (stk_rdata)
    );

    // Control state: matrix, count register, stack count, edge budget, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_VERTICES; r++) begin
                r_rows[r] <= '0;
            end
            r_vcnt      <= VCNT_W'(VCNT_RESET);
            r_count     <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcnt <= i_cfg_wdata;
            end
            for (int r = 0; r < MAX_VERTICES; r++) begin
                if (i_cmd.load_row && (VTX_W'(r) == i_row_index)) begin
                    r_rows[r] <= ROW_W'(i_row_bits);
                end else if (i_cmd.take_edge) begin
                    r_rows[r] <= r_rows[r] & ~clr[r];
                end
            end
            if (i_cmd.walk_init) begin
                r_count <= CNT_W'(1);
                r_taken <= '0;
            end else if (i_cmd.pop) begin
                r_count <= cnt_dec;
            end else if (i_cmd.take_edge) begin
                r_count <= r_count + CNT_W'(1);
                r_taken <= r_taken + TAKEN_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: current vertex and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_u) begin
            r_u <= stk_rdata;
        end else if (i_cmd.take_edge) begin
            r_u <= v_sel;
        end
        if (i_cmd.emit) begin
            r_out_vertex <= r_u;
            r_out_last   <= (r_count == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_vertex_out  = r_out_vertex;
    assign o_last_vertex = r_out_last;

    // Checks
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_edge |-> (r_count < CNT_W'(STACK_DEPTH)))
        else $error("edge taken with a full stack");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while held");

    a_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_taken < TAKEN_W'(RESULT_LIMIT))
        else $error("edge budget exceeded");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("pop from an empty stack");

endmodule

`default_nettype wire

// ----- rtl/ecw_ctrl.sv -----
// Controller of the Euler circuit walker: sequences loads, pops, scans and emits.
// Depends on ecw_pkg.
`default_nettype none

module ecw_ctrl import ecw_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    input  wire logic     i_req_type,
    input  wire t_dp_stat i_stat,
    output logic          o_req_ready,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_READ,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_type == REQ_WALK) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_POP;
                    end else begin
                        o_cmd.load_row = 1'b1;
                    end
                end
            end
            S_POP: begin
                if (i_stat.stack_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                o_cmd.load_u = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.edge_ok) begin
                    o_cmd.take_edge = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/euler_circuit_walker_core.sv -----
// Euler circuit walker: a load item writes one adjacency row and gives no result.
// A walk item pops vertices off a stack: each popped vertex passes the pop, stack RAM
// read and scan states, and every edge taken is a further step in the scan state.
// The first result is emitted once the path from the start vertex runs out of edges, stack room or edge budget.
// One item at a time; the last result may wait in the output register while the next
// transaction is taken. Synchronous active-low reset clears matrix, count (to 8), state.
`default_nettype none

module euler_circuit_walker_core import ecw_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [VCNT_W-1:0] i_cfg_wdata,
    ecw_in_if.sink             i_req,
    ecw_out_if.source          o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     req_ready;

    ecw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_stat      (stat),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    ecw_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_row_index    (i_req.row_index),
        .i_row_bits     (i_req.row_bits),
        .i_start_vertex (i_req.start_vertex),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_vertex_out   (o_rsp.vertex_out),
        .o_last_vertex  (o_rsp.last_vertex)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire

// ----- tb/ecw_circuit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Euler circuit walker: snoops the request and result channels and the
// vertex-count port, predicts each walk's emitted vertices and compares them in order.
// Depends on ecw_pkg, ecw_in_if and ecw_out_if.

module ecw_circuit_checker import ecw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_wdata,
    ecw_in_if                 i_req,
    ecw_out_if                i_rsp,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic             last;
    } t_vertex_exp;

    // Shadow copy of the block's state
    logic [ROW_W-1:0]  adj_rows [MAX_VERTICES];
    logic [VCNT_W-1:0] vertex_count = VCNT_W'(VCNT_RESET);
    t_vertex_exp       circuit_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        foreach (adj_rows[r]) adj_rows[r] = '0;
    end

    // Stack walk over the shadow matrix; queues one expected vertex per pop
    task automatic predict_circuit(input logic [VTX_W-1:0] start);
        logic [VTX_W-1:0] vtx_stack [STACK_DEPTH];
        int unsigned      n;
        int unsigned      u;
        int unsigned      v;
        int unsigned      depth;
        int unsigned      taken;
        int unsigned      emitted;
        n       = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
        taken   = 0;
        emitted = 0;
        vtx_stack[0] = start;
        depth   = 1;
        while (depth > 0) begin
            depth--;
            u = vtx_stack[depth];
            v = 0;
            while (v < n) begin
                // edge budget: stack room and a taken count below RESULT_LIMIT-1
                if (u < MAX_VERTICES && adj_rows[u][v] && depth < STACK_DEPTH &&
                    taken + 1 < RESULT_LIMIT) begin
                    adj_rows[u][v] = 1'b0;
                    adj_rows[v][u] = 1'b0;
                    vtx_stack[depth] = u[VTX_W-1:0];
                    depth++;
                    u = v;
                    v = 0;
                    taken++;
                end else begin
                    v++;
                end
            end
            if (emitted < RESULT_LIMIT) begin
                circuit_q.push_back('{vertex: u[VTX_W-1:0], last: (depth == 0)});
                emitted++;
            end
        end
    endtask

    // Monitor: results are compared before a new walk is predicted
    always @(posedge i_clk) begin
        t_vertex_exp want;
        if (!i_rst_n) begin
            foreach (adj_rows[r]) adj_rows[r] = '0;
            vertex_count = VCNT_W'(VCNT_RESET);
            circuit_q.delete();
        end else begin
            if (i_cfg_we)
                vertex_count = i_cfg_wdata;
            if (i_rsp.valid && i_rsp.ready) begin
                if (circuit_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected vertex %0d last %0b, nothing outstanding",
                             $time, i_rsp.vertex_out, i_rsp.last_vertex);
                end else begin
                    want = circuit_q.pop_front();
                    o_checked++;
                    if (i_rsp.vertex_out !== want.vertex || i_rsp.last_vertex !== want.last) begin
                        o_fail_count++;
                        $display("%0t: vertex mismatch, expected %0d last %0b, got %0d last %0b",
                                 $time, want.vertex, want.last,
                                 i_rsp.vertex_out, i_rsp.last_vertex);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.req_type == REQ_LOAD)
                    adj_rows[i_req.row_index] = i_req.row_bits;
                else
                    predict_circuit(i_req.start_vertex);
            end
        end
        o_pending = circuit_q.size();
    end

endmodule

// ----- tb/tb_euler_circuit_walker_core.sv -----
`timescale 1ns / 1ps
// Top of the Euler circuit walker testbench: clock, reset, request and result-side
// stimulus in several idling phases, vertex-count writes and the final verdict.
// Depends on ecw_pkg, ecw_in_if, ecw_out_if, ecw_circuit_checker and the core.

module tb_euler_circuit_walker_core;
    import ecw_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 200;

    typedef logic [ROW_W-1:0] t_rows [MAX_VERTICES];

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [VCNT_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_len      = 0;
    int hold_req_cnt  = 0;
    int items_sent    = 0;
    int walks_sent    = 0;
    int cycle_count   = 0;

    ecw_in_if  req_if ();
    ecw_out_if rsp_if ();

    euler_circuit_walker_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    ecw_circuit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: run stopped after %0d cycles", $time, cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req_cnt) begin
                hold_seen = hold_req_cnt;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // One request transaction; returns on the falling edge after acceptance
    task automatic offer_request(input logic kind, input logic [VTX_W-1:0] idx,
                                 input logic [ROWBITS_W-1:0] bits,
                                 input logic [VTX_W-1:0] start);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.row_index    <= idx;
        req_if.row_bits     <= bits;
        req_if.start_vertex <= start;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        @(negedge i_clk);
        items_sent++;
        if (kind == REQ_WALK)
            walks_sent++;
    endtask

    task automatic load_row(input int idx, input int bits);
        offer_request(REQ_LOAD, idx[VTX_W-1:0], bits[ROWBITS_W-1:0],
                      VTX_W'($urandom_range(7)));
    endtask

    task automatic start_walk(input int start);
        offer_request(REQ_WALK, VTX_W'($urandom_range(7)), ROWBITS_W'($urandom_range(255)),
                      start[VTX_W-1:0]);
    endtask

    // Sender pauses until every outstanding vertex has been returned
    task automatic drain_results();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_vertex_count(input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[VCNT_W-1:0];
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // XOR of random closed walks: every vertex ends with even degree
    function automatic t_rows make_even_graph();
        t_rows g;
        int    a;
        int    b;
        int    first;
        int    len;
        foreach (g[r]) g[r] = '0;
        repeat ($urandom_range(1, 4)) begin
            len   = $urandom_range(1, 6);
            first = $urandom_range(MAX_VERTICES - 1);
            a     = first;
            for (int step = 0; step < len; step++) begin
                b = (step == len - 1) ? first : $urandom_range(MAX_VERTICES - 1);
                g[a][b] ^= 1'b1;
                if (a != b)
                    g[b][a] ^= 1'b1;
                a = b;
            end
        end
        return g;
    endfunction

    // Load all rows of a graph in shuffled order
    task automatic send_graph(input t_rows g);
        int order [MAX_VERTICES];
        int j;
        int tmp;
        foreach (order[k]) order[k] = k;
        for (int k = MAX_VERTICES - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        foreach (order[k]) load_row(order[k], g[order[k]]);
    endtask

    // Mostly full graph reloads followed by a walk; the rest partial loads and stale walks
    task automatic run_phase(input int count);
        int    base;
        int    pick;
        int    start;
        t_rows g;
        base = items_sent;
        while (items_sent - base < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                g     = make_even_graph();
                send_graph(g);
                start = $urandom_range(MAX_VERTICES - 1);
                repeat (4)
                    if (g[start] == '0)
                        start = $urandom_range(MAX_VERTICES - 1);
                start_walk(start);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 3))
                    load_row($urandom_range(MAX_VERTICES - 1), $urandom_range(255));
                start_walk($urandom_range(MAX_VERTICES - 1));
            end else begin
                start_walk($urandom_range(MAX_VERTICES - 1));
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_LOAD;
        req_if.row_index    = '0;
        req_if.row_bits     = '0;
        req_if.start_vertex = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty matrix: only the start vertex comes back
        start_walk(7);

        // edges 0-1 and 0-2 with a self loop at 1, and a one-sided entry 3->4
        load_row(0, 8'b0000_0110);
        load_row(1, 8'b0000_0011);
        load_row(2, 8'b0000_0001);
        load_row(3, 8'b0001_0000);
        load_row(4, 8'b0000_0000);
        start_walk(0);
        start_walk(3);

        // count above the array; full matrix runs into the edge budget
        write_vertex_count(15);
        for (int r = 0; r < MAX_VERTICES; r++)
            load_row(r, 8'hFF);
        start_walk(7);
        start_walk(0);

        // zero count scans nothing
        write_vertex_count(0);
        start_walk(5);

        // single column: self loop at 0, then 6 reaches only column 0
        write_vertex_count(1);
        load_row(0, 8'h01);
        load_row(6, 8'hFF);
        start_walk(0);
        start_walk(6);

        // no idling, with a long result hold-off while requests keep coming
        write_vertex_count(VCNT_RESET);
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_len      = 400;
        hold_req_cnt++;
        run_phase(12);
        drain_results();
        run_phase(10);

        // sparse requests
        write_vertex_count($urandom_range(1, 15));
        send_idle_pct = 77;
        rsp_stall_pct = 0;
        run_phase(26);

        // heavy result back-pressure
        write_vertex_count(VCNT_RESET);
        send_idle_pct = 0;
        rsp_stall_pct = 77;
        run_phase(26);

        // light idling on both sides
        write_vertex_count($urandom_range(4, 8));
        send_idle_pct = 12;
        rsp_stall_pct = 12;
        run_phase(26);

        drain_results();
        repeat (END_CYCLES) @(negedge i_clk);

        $display("Sent %0d requests (%0d walks), compared %0d emitted vertices", items_sent,
                 walks_sent, checked);
        $display("Vertex counts 0, 1, 8, 15 and random; idle, stall and hold-off phases");
        if (pending != 0)
            $display("%0t: %0d expected vertices never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
